[src/jpwt_pkg.sv]
// Shared types, constants and register codes for the patch window trigger.
// No dependencies; used by every module in src.
`default_nettype none
package jpwt_pkg;
	localparam int GRID_ROWS     = 32;
	localparam int GRID_COLS     = 32;
	localparam int WINDOW_STRIDE = 4;
	localparam int ADC_BITS      = 12;
	localparam int MAX_PATCHES   = 49;
	localparam int SUM_MAX       = 1048575;

	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int COL_AW = $clog2(GRID_COLS);
	localparam int ROW_BITS = GRID_COLS * ADC_BITS;
	// column sum over up to 16 rows, window sum over up to 16 columns
	localparam int COL_W  = ADC_BITS + 4;
	localparam int WIN_W  = (ADC_BITS + 8 > 21) ? ADC_BITS + 8 : 21;
	localparam int PH_W   = (WINDOW_STRIDE > 1) ? $clog2(WINDOW_STRIDE) : 1;
	localparam int CFG_W  = 20;

	typedef enum logic [2:0] {
		REG_THRESHOLD_HIGH = 3'd0,
		REG_THRESHOLD_LOW  = 3'd1,
		REG_HIGH_BIT_POS   = 3'd2,
		REG_LOW_BIT_POS    = 3'd3,
		REG_WINDOW_MODE    = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_SHIFT,
		ST_COUNT
	} state_t;

	typedef struct packed {
		logic        action;
		logic [4:0]  cell_row;
		logic [4:0]  cell_col;
		logic [11:0] adc_value;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  patch_col;
		logic [4:0]  patch_row;
		logic [19:0] window_sum;
		logic [31:0] trigger_mask;
		logic [4:0]  patch_size;
		logic        is_count_item;
		logic [5:0]  patch_count;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic shift;
	} cell_ctrl_t;
endpackage
`default_nettype wire

[src/jpwt_grid_mem.sv]
// Row-wide ADC grid memory: one row per word, single cell or whole-row writes.
// Depends on jpwt_pkg.
`default_nettype none
module jpwt_grid_mem (
	input  wire logic                         clk,
	input  wire logic                         clr_en,
	input  wire logic [jpwt_pkg::ROW_W-1:0]   clr_row,
	input  wire logic                         wr_en,
	input  wire logic [jpwt_pkg::ROW_W-1:0]   wr_row,
	input  wire logic [jpwt_pkg::COL_AW-1:0]  wr_col,
	input  wire logic [jpwt_pkg::ADC_BITS-1:0] wr_data,
	input  wire logic                         rd_en,
	input  wire logic [jpwt_pkg::ROW_W-1:0]   rd_row,
	output logic [jpwt_pkg::ROW_BITS-1:0]     rd_data
);
	logic [jpwt_pkg::ROW_BITS-1:0] mem_q [jpwt_pkg::GRID_ROWS];

	always_ff @(posedge clk) begin
		if (clr_en) begin
			mem_q[clr_row] <= '0;
		end else if (wr_en) begin
			mem_q[wr_row][wr_col*jpwt_pkg::ADC_BITS +: jpwt_pkg::ADC_BITS] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_row];
		end
	end
endmodule
`default_nettype wire

[src/jpwt_col_cell.sv]
// One column cell: accumulates its column sum over a row band, then shifts
// it toward the head of the chain. Depends on jpwt_pkg.
`default_nettype none
module jpwt_col_cell (
	input  wire logic                          clk,
	input  wire jpwt_pkg::cell_ctrl_t          ctrl,
	input  wire logic [jpwt_pkg::ADC_BITS-1:0] pix,
	input  wire logic [jpwt_pkg::COL_W-1:0]    from_right,
	output logic [jpwt_pkg::COL_W-1:0]         sum
);
	logic [jpwt_pkg::COL_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			sum_q <= '0;
		end else if (ctrl.shift) begin
			sum_q <= from_right;
		end else if (ctrl.acc) begin
			sum_q <= sum_q + jpwt_pkg::COL_W'(pix);
		end
	end

	assign sum = sum_q;
endmodule
`default_nettype wire

[src/jet_patch_window_trigger.sv]
// Top level of the sliding window trigger: control, column cell chain, output.
// Depends on jpwt_pkg, jpwt_grid_mem and jpwt_col_cell.
//
// Input words: action 0 writes one ADC cell (no result); action 1
// evaluates all windows. Cells outside the grid are ignored.
// An evaluation walks row bands whose first row steps by the stride. Per band
// the grid memory delivers one row a cycle into a chain of column cells, then
// the chain shifts its column sums out one per cycle, holding while an output
// word waits on out_ready, through a sliding window adder. Each firing window,
// up to MAX_PATCHES, gives one patch word in row-major order; a count word
// with last set closes the evaluation. Only one evaluation is in work at a time.
// After reset a clearing pass zeroes the grid one row a cycle with in_ready
// low; configuration writes are taken at any time. While a word waits and
// out_ready is low the scan holds; the output register keeps the word.
`default_nettype none
module jet_patch_window_trigger (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire jpwt_pkg::in_word_t         in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output jpwt_pkg::out_word_t             out_data,
	input  wire logic                       cfg_wr_en,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [jpwt_pkg::CFG_W-1:0] cfg_data
);
	localparam int NC = jpwt_pkg::GRID_COLS;

	// configuration
	logic [19:0] th_high_q, th_low_q;
	logic [4:0]  hb_pos_q, lb_pos_q;
	logic        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_high_q <= '0;
			th_low_q  <= '0;
			hb_pos_q  <= 5'd0;
			lb_pos_q  <= 5'd1;
			mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (jpwt_pkg::reg_index_t'(cfg_index))
				jpwt_pkg::REG_THRESHOLD_HIGH: th_high_q <= cfg_data[19:0];
				jpwt_pkg::REG_THRESHOLD_LOW:  th_low_q  <= cfg_data[19:0];
				jpwt_pkg::REG_HIGH_BIT_POS:   hb_pos_q  <= cfg_data[4:0];
				jpwt_pkg::REG_LOW_BIT_POS:    lb_pos_q  <= cfg_data[4:0];
				jpwt_pkg::REG_WINDOW_MODE:    mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control state
	jpwt_pkg::state_t state_q, state_d;
	logic [jpwt_pkg::ROW_W-1:0]  clr_row_q, clr_row_d;
	logic [jpwt_pkg::ROW_W:0]    r0_q, r0_d;
	logic [4:0]                  rcnt_q, rcnt_d;
	logic [jpwt_pkg::COL_AW-1:0] k_q, k_d;
	logic [jpwt_pkg::PH_W-1:0]   ph_q, ph_d;
	logic [5:0]                  cnt_q, cnt_d;
	logic                        size8_q, size8_d;
	logic                        rd_vld_s1;
	logic [jpwt_pkg::WIN_W-1:0]  run_q, run_d;

	logic [4:0]                  size;
	logic                        out_free, out_load;
	jpwt_pkg::out_word_t         out_q, out_word;
	logic                        rd_en, mem_wr, clr_en;
	logic [jpwt_pkg::ROW_W-1:0]  rd_row;
	logic [jpwt_pkg::ROW_BITS-1:0] rd_data;
	jpwt_pkg::cell_ctrl_t        ctrl;
	logic [jpwt_pkg::COL_W-1:0]  col_sum [NC+1];
	logic [jpwt_pkg::COL_W-1:0]  dly_q [16];
	logic [jpwt_pkg::COL_W-1:0]  tap;
	logic [jpwt_pkg::WIN_W-1:0]  sum_new;
	logic [19:0]                 sum_sat;
	logic [31:0]                 mask;
	logic [jpwt_pkg::COL_AW:0]   c0;
	logic                        win_done, last_col;
	logic [jpwt_pkg::ROW_W+1:0]  next_r0;

	assign size     = size8_q ? 5'd8 : 5'd16;
	assign out_free = !out_valid || out_ready;
	assign last_col = (k_q == jpwt_pkg::COL_AW'(NC - 1));
	assign next_r0  = (jpwt_pkg::ROW_W+2)'(r0_q) + (jpwt_pkg::ROW_W+2)'(jpwt_pkg::WINDOW_STRIDE);

	// sliding window over the column sums leaving the chain head
	assign tap     = size8_q ? dly_q[7] : dly_q[15];
	assign sum_new = run_q + jpwt_pkg::WIN_W'(col_sum[0])
		- ((int'(k_q) >= int'(size)) ? jpwt_pkg::WIN_W'(tap) : '0);
	assign sum_sat = (sum_new > jpwt_pkg::WIN_W'(jpwt_pkg::SUM_MAX))
		? 20'(jpwt_pkg::SUM_MAX) : sum_new[19:0];
	assign mask    = ((sum_sat > th_high_q) ? (32'd1 << hb_pos_q) : 32'd0)
		| ((sum_sat > th_low_q) ? (32'd1 << lb_pos_q) : 32'd0);
	assign c0       = (jpwt_pkg::COL_AW+1)'(k_q) - (jpwt_pkg::COL_AW+1)'(size - 5'd1);
	assign win_done = (int'(k_q) >= int'(size) - 1) && (ph_q == '0);

	always_comb begin
		state_d   = state_q;
		clr_row_d = clr_row_q;
		r0_d      = r0_q;
		rcnt_d    = rcnt_q;
		k_d       = k_q;
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		size8_d   = size8_q;
		run_d     = run_q;
		in_ready  = 1'b0;
		clr_en    = 1'b0;
		mem_wr    = 1'b0;
		rd_en     = 1'b0;
		rd_row    = '0;
		ctrl      = '0;
		out_load  = 1'b0;
		out_word  = '0;
		unique case (state_q)
			jpwt_pkg::ST_CLEAR: begin
				clr_en    = 1'b1;
				clr_row_d = clr_row_q + 1'b1;
				if (clr_row_q == jpwt_pkg::ROW_W'(jpwt_pkg::GRID_ROWS - 1)) begin
					state_d = jpwt_pkg::ST_IDLE;
				end
			end
			jpwt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_data.action) begin
						mem_wr = (int'(in_data.cell_row) < jpwt_pkg::GRID_ROWS)
							&& (int'(in_data.cell_col) < jpwt_pkg::GRID_COLS);
					end else begin
						size8_d  = mode_q;
						r0_d     = '0;
						rcnt_d   = '0;
						cnt_d    = '0;
						ctrl.clr = 1'b1;
						state_d  = jpwt_pkg::ST_ACC;
					end
				end
			end
			jpwt_pkg::ST_ACC: begin
				if (rcnt_q == size) begin
					k_d     = '0;
					ph_d    = '0;
					run_d   = '0;
					state_d = jpwt_pkg::ST_SHIFT;
				end else begin
					rd_en  = 1'b1;
					rd_row = jpwt_pkg::ROW_W'(r0_q + (jpwt_pkg::ROW_W+1)'(rcnt_q));
					rcnt_d = rcnt_q + 5'd1;
				end
			end
			jpwt_pkg::ST_SHIFT: begin
				if (out_free) begin
					ctrl.shift = 1'b1;
					run_d      = sum_new;
					k_d        = k_q + 1'b1;
					if (int'(k_q) >= int'(size) - 1) begin
						ph_d = (ph_q == jpwt_pkg::PH_W'(jpwt_pkg::WINDOW_STRIDE - 1))
							? '0 : ph_q + 1'b1;
					end
					if (win_done && (mask != '0) && (int'(cnt_q) < jpwt_pkg::MAX_PATCHES)) begin
						out_load              = 1'b1;
						out_word.patch_col    = c0[4:0];
						out_word.patch_row    = r0_q[4:0];
						out_word.window_sum   = sum_sat;
						out_word.trigger_mask = mask;
						out_word.patch_size   = size;
						cnt_d                 = cnt_q + 6'd1;
					end
					if (last_col) begin
						if (int'(next_r0) + int'(size) <= jpwt_pkg::GRID_ROWS) begin
							r0_d     = next_r0[jpwt_pkg::ROW_W:0];
							rcnt_d   = '0;
							ctrl.clr = 1'b1;
							state_d  = jpwt_pkg::ST_ACC;
						end else begin
							state_d = jpwt_pkg::ST_COUNT;
						end
					end
				end
			end
			jpwt_pkg::ST_COUNT: begin
				if (out_free) begin
					out_load               = 1'b1;
					out_word.patch_size    = size;
					out_word.is_count_item = 1'b1;
					out_word.patch_count   = cnt_q;
					out_word.last          = 1'b1;
					state_d                = jpwt_pkg::ST_IDLE;
				end
			end
			default: state_d = jpwt_pkg::ST_IDLE;
		endcase
		ctrl.acc = rd_vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= jpwt_pkg::ST_CLEAR;
			clr_row_q <= '0;
			r0_q      <= '0;
			rcnt_q    <= '0;
			k_q       <= '0;
			ph_q      <= '0;
			cnt_q     <= '0;
			size8_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_row_q <= clr_row_d;
			r0_q      <= r0_d;
			rcnt_q    <= rcnt_d;
			k_q       <= k_d;
			ph_q      <= ph_d;
			cnt_q     <= cnt_d;
			size8_q   <= size8_d;
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_q <= run_d;
		if (out_load) begin
			out_q <= out_word;
		end
		if (ctrl.shift) begin
			dly_q[0] <= col_sum[0];
			for (int i = 1; i < 16; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign out_data = out_q;

	jpwt_grid_mem u_mem (
		.clk     (clk),
		.clr_en  (clr_en),
		.clr_row (clr_row_q),
		.wr_en   (mem_wr),
		.wr_row  (jpwt_pkg::ROW_W'(in_data.cell_row)),
		.wr_col  (jpwt_pkg::COL_AW'(in_data.cell_col)),
		.wr_data (jpwt_pkg::ADC_BITS'(in_data.adc_value)),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	assign col_sum[NC] = '0;
	for (genvar j = 0; j < NC; j++) begin : g_cell
		jpwt_col_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pix        (rd_data[j*jpwt_pkg::ADC_BITS +: jpwt_pkg::ADC_BITS]),
			.from_right (col_sum[j+1]),
			.sum        (col_sum[j])
		);
	end

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_count_item |-> out_data.last)
		else $error("count word without last");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= jpwt_pkg::MAX_PATCHES)
		else $error("patch count beyond cap");
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpwt_pkg::ST_CLEAR |-> !in_ready)
		else $error("input taken during grid clear");
	a_size_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jpwt_pkg::ST_SHIFT || state_q == jpwt_pkg::ST_ACC)
		|=> $stable(size8_q))
		else $error("window size changed during evaluation");
endmodule
`default_nettype wire
